@@ hdl/utf8ld_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8ld_pkg
// Shared widths and the result packet passed from the decode front end
// through the queue to the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8ld_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;

  // up to two code points produced by one input byte
  typedef struct packed {
    logic            two;
    logic [CP_W-1:0] cp0;
    logic [CP_W-1:0] cp1;
  } pkt_t;

endpackage

`default_nettype wire

@@ hdl/utf8ld_if.sv @@
// ----------------------------------------------------------------------------
// utf8ld channel interfaces
// Valid/ready channels for the byte stream in and the code point stream out.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8ld_byte_if;
  logic                         valid;
  logic                         ready;
  logic [utf8ld_pkg::BYTE_W-1:0] data_byte;
  logic                         string_last;

  modport source (output valid, output data_byte, output string_last, input ready);
  modport sink   (input valid, input data_byte, input string_last, output ready);
endinterface

interface utf8ld_cp_if;
  logic                       valid;
  logic                       ready;
  logic [utf8ld_pkg::CP_W-1:0] code_point;
  logic                       run_end;

  modport source (output valid, output code_point, output run_end, input ready);
  modport sink   (input valid, input code_point, input run_end, output ready);
endinterface

`default_nettype wire

@@ hdl/utf8_lenient_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_lenient_decoder
// Lenient UTF-8 decoder, one byte in per transaction, code points out.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle while the queue has room; its only
// parameter is the queue depth. Each byte is decoded in the cycle it is
// accepted into a packet of zero, one or two code points, which goes through
// a small queue to the output sequencer. The sequencer sends one code point
// per cycle while the output is ready; a packet holds two code points only
// when a string ends inside a sequence. A byte reaches the output through
// the queue storage and then the packet register. Bytes are accepted while
// the queue has room, also while a code point waits at the output.
`default_nettype none

module utf8_lenient_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst,
  utf8ld_byte_if.sink  byte_stream,
  utf8ld_cp_if.source  code_stream
);
  import utf8ld_pkg::*;

  pkt_t push_pkt;
  pkt_t head_pkt;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  // decode front end
  utf8ld_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_stream),
    .full  (full),
    .pkt   (push_pkt),
    .push  (push)
  );

  // decoupling queue
  utf8ld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pkt   (push_pkt),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_pkt   (head_pkt)
  );

  // output sequencer
  utf8ld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_pkt   (head_pkt),
    .pop        (pop),
    .points     (code_stream)
  );

endmodule

`default_nettype wire

@@ hdl/utf8ld_front.sv @@
// ----------------------------------------------------------------------------
// utf8ld_front
// Accepts bytes, tracks the pending multi-byte sequence and turns each byte
// into a packet of zero, one or two code points.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8ld_front (
  input  wire logic             clk,
  input  wire logic             rst,
  utf8ld_byte_if.sink           bytes,
  input  wire logic             full,
  output utf8ld_pkg::pkt_t      pkt,
  output logic                  push
);
  import utf8ld_pkg::*;

  // sequence length codes, zero means no sequence pending
  localparam logic [2:0] LEN_IDLE  = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [2:0] len;
    if (!b[7])                        len = LEN_ONE;
    else if ((b & 8'hE0) == 8'hC0)    len = LEN_TWO;
    else if ((b & 8'hF0) == 8'hE0)    len = LEN_THREE;
    else if ((b & 8'hF8) == 8'hF0)    len = LEN_FOUR;
    else                              len = LEN_IDLE;
    return len;
  endfunction

  logic [BYTE_W-1:0] held_bytes [3];
  logic [1:0]        held_count, held_count_next;
  logic [2:0]        needed_length, needed_length_next;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic              last;
  logic [2:0]        len_b;
  logic [2:0]        cnt_inc;
  logic              complete;
  logic              store;
  logic [CP_W-1:0]   cp_seq;
  logic [CP_W-1:0]   b_cp;
  logic [CP_W-1:0]   h1_cp;
  logic [BYTE_W-1:0] h1;
  logic [1:0]        n;

  assign bytes.ready = !full;
  assign accept      = bytes.valid && bytes.ready;
  assign b           = bytes.data_byte;
  assign last        = bytes.string_last;
  assign h1          = held_bytes[1];
  assign b_cp        = {{(CP_W-BYTE_W){1'b0}}, b};
  assign h1_cp       = {{(CP_W-BYTE_W){1'b0}}, h1};

  // assemble a completed sequence
  always_comb begin
    unique case (needed_length)
      LEN_TWO:   cp_seq = {10'd0, held_bytes[0][4:0], b[5:0]};
      LEN_THREE: cp_seq = {5'd0, held_bytes[0][3:0], h1[5:0], b[5:0]};
      default:   cp_seq = {held_bytes[0][2:0], h1[5:0], held_bytes[2][5:0], b[5:0]};
    endcase
  end

  // decode of one byte against the pending sequence
  always_comb begin
    len_b              = lead_len(b);
    cnt_inc            = {1'b0, held_count} + 3'd1;
    complete           = (needed_length != LEN_IDLE) && (cnt_inc >= needed_length);
    store              = 1'b0;
    n                  = 2'd0;
    pkt.cp0            = b_cp;
    pkt.cp1            = b_cp;
    held_count_next    = held_count;
    needed_length_next = needed_length;

    if (needed_length == LEN_IDLE) begin
      if (len_b == LEN_ONE) begin
        n = 2'd1;
      end else if (len_b != LEN_IDLE && !last) begin
        store              = 1'b1;
        held_count_next    = 2'd1;
        needed_length_next = len_b;
      end
    end else if (complete) begin
      n                  = 2'd1;
      pkt.cp0            = cp_seq;
      held_count_next    = 2'd0;
      needed_length_next = LEN_IDLE;
    end else if (last) begin
      // truncated sequence: drop the lead, decode the bytes after it afresh
      if (held_count != 2'd2) begin
        if (!b[7]) n = 2'd1;
      end else if (!h1[7]) begin
        pkt.cp0 = h1_cp;
        n       = b[7] ? 2'd1 : 2'd2;
      end else if ((h1 & 8'hE0) == 8'hC0) begin
        pkt.cp0 = {10'd0, h1[4:0], b[5:0]};
        n       = 2'd1;
      end else if (!b[7]) begin
        n = 2'd1;
      end
    end else begin
      store           = 1'b1;
      held_count_next = cnt_inc[1:0];
    end

    // a string end always returns to idle
    if (last) begin
      held_count_next    = 2'd0;
      needed_length_next = LEN_IDLE;
    end
    pkt.two = (n == 2'd2);
    push    = accept && (n != 2'd0);
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= 2'd0;
      needed_length <= LEN_IDLE;
    end else if (accept) begin
      held_count    <= held_count_next;
      needed_length <= needed_length_next;
    end
  end

  // held bytes, lead byte goes to entry zero
  always_ff @(posedge clk) begin
    if (accept && store) begin
      if (needed_length == LEN_IDLE) begin
        held_bytes[0] <= b;
      end else if (held_count != 2'd3) begin
        held_bytes[held_count] <= b;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/utf8ld_queue.sv @@
// ----------------------------------------------------------------------------
// utf8ld_queue
// Small packet queue between the decode front end and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8ld_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire utf8ld_pkg::pkt_t  push_pkt,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output utf8ld_pkg::pkt_t       head_pkt
);
  import utf8ld_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pkt_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full       = (fill == CNT_FULL);
  assign head_valid = (fill != '0);
  assign head_pkt   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_pkt;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      fill <= fill + CNT_W'(1);
      else if (do_pop && !do_push) fill <= fill - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ hdl/utf8ld_back.sv @@
// ----------------------------------------------------------------------------
// utf8ld_back
// Output sequencer: holds one packet and hands out its code points one
// transaction at a time, marking the last one of the packet.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8ld_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire utf8ld_pkg::pkt_t  head_pkt,
  output logic                   pop,
  utf8ld_cp_if.source            points
);
  import utf8ld_pkg::*;

  pkt_t cur;
  logic cur_valid;
  logic second;
  logic fire;
  logic done;

  assign points.valid      = cur_valid;
  assign points.code_point = second ? cur.cp1 : cur.cp0;
  assign points.run_end    = second || !cur.two;

  assign fire = cur_valid && points.ready;
  assign done = fire && points.run_end;
  assign pop  = head_valid && (!cur_valid || done);

  // packet register
  always_ff @(posedge clk) begin
    if (pop) cur <= head_pkt;
  end

  // sequencing control
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      second    <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      second    <= 1'b0;
    end else if (done) begin
      cur_valid <= 1'b0;
      second    <= 1'b0;
    end else if (fire) begin
      second    <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/utf8ld_checker.sv @@
// ----------------------------------------------------------------------------
// utf8ld_checker
// Port-level checks of the decoder output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8ld_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [utf8ld_pkg::CP_W-1:0] code_point,
  input wire logic                       run_end
);

  // nothing leaves the block right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // the second code point of a pair follows straight away
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_end |=> out_valid)
    else $error("second code point of a pair missing");

  // a first code point of a pair only comes from an ascii byte
  a_pair_head_ascii: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_end |-> code_point[20:7] == '0)
    else $error("first code point of a pair is not ascii");

  // stalled transaction keeps its payload
  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(run_end))
    else $error("output changed while stalled");

endmodule

bind utf8_lenient_decoder utf8ld_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (code_stream.valid),
  .out_ready  (code_stream.ready),
  .code_point (code_stream.code_point),
  .run_end    (code_stream.run_end)
);

`default_nettype wire
